FILE: rtl/i2c_tag_word_packer_defines.svh
// Assertion macros shared by the tag word packer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef I2C_TAG_WORD_PACKER_DEFINES_SVH
`define I2C_TAG_WORD_PACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ITWP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITWP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/itwp_pkg.sv
// Shared types and constants of the I2C tag word packer.
// Used by itwp_in_stage, itwp_pack_stage and i2c_tag_word_packer.
package itwp_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  localparam logic [2:0] TAG_START = 3'd1;
  localparam logic [2:0] TAG_DATA  = 3'd2;
  localparam logic [2:0] TAG_STOP  = 3'd3;
  localparam logic [2:0] TAG_RECV  = 3'd4;

  localparam int unsigned HALF_W = 16;
  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    opcode_t     opcode;
    logic [6:0]  slave_address;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] read_length;
  } item_t;

  // Handshake between the input stage and the pack stage.
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

FILE: rtl/itwp_in_stage.sv
// Input register of the tag word packer: unpacks the input beat and holds it.
// Depends on itwp_pkg.
module itwp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // slave_address[6:0], data_byte[14:7],
                                           // read_length[30:15], zero[31]
  input  logic [1:0]           in_tuser,   // opcode[0], first_byte[1]
  input  logic                 in_tlast,   // last_byte
  output itwp_pkg::stage_t     stg,
  input  logic                 stg_ready
);

  logic            valid_r;
  logic            valid_nxt;
  itwp_pkg::item_t item_r;
  itwp_pkg::item_t item_nxt;

  assign in_tready = !valid_r || stg_ready;

  always_comb begin
    item_nxt = item_r;
    valid_nxt = valid_r && !stg_ready;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
      item_nxt.opcode        = itwp_pkg::opcode_t'(in_tuser[0]);
      item_nxt.first_byte    = in_tuser[1];
      item_nxt.last_byte     = in_tlast;
      item_nxt.slave_address = in_tdata[6:0];
      item_nxt.data_byte     = in_tdata[14:7];
      item_nxt.read_length   = in_tdata[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign stg.valid = valid_r;
  assign stg.item  = item_r;

endmodule

FILE: rtl/itwp_pack_stage.sv
// Pairing logic and result register of the tag word packer.
// Depends on itwp_pkg and i2c_tag_word_packer_defines.svh.
`include "i2c_tag_word_packer_defines.svh"

module itwp_pack_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  itwp_pkg::stage_t stg,
  output logic             stg_ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata    // fifo_word[31:0]
);

  logic [15:0] pending_half_r;
  logic [15:0] pending_half_nxt;
  logic        upper_next_r;
  logic        upper_next_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_data_r;
  logic [31:0] out_data_nxt;

  logic        take;
  logic        emit;
  logic [7:0]  rd_len;
  logic [15:0] pend;
  logic        up;
  logic [15:0] half;
  logic [31:0] word;

  assign stg_ready = !out_valid_r || out_tready;
  assign take      = stg.valid && stg_ready;

  // Lengths of 256 and above do not fit the receive half and encode as zero.
  assign rd_len = (|stg.item.read_length[15:8]) ? 8'd0 : stg.item.read_length[7:0];

  always_comb begin
    pend = stg.item.first_byte ?
           {5'd0, itwp_pkg::TAG_START, stg.item.slave_address, 1'b0} : pending_half_r;
    up   = stg.item.first_byte || upper_next_r;
    half = {5'd0, (stg.item.last_byte ? itwp_pkg::TAG_STOP : itwp_pkg::TAG_DATA),
            stg.item.data_byte};

    pending_half_nxt = pending_half_r;
    upper_next_nxt   = upper_next_r;
    emit             = 1'b0;
    word             = '0;

    if (stg.item.opcode == itwp_pkg::OP_READ) begin
      emit = 1'b1;
      word = {5'd0, itwp_pkg::TAG_RECV, rd_len,
              5'd0, itwp_pkg::TAG_START, stg.item.slave_address, 1'b1};
      pending_half_nxt = '0;
      upper_next_nxt   = 1'b0;
    end else if (up) begin
      emit = 1'b1;
      word = {half, pend};
      pending_half_nxt = '0;
      upper_next_nxt   = 1'b0;
    end else if (stg.item.last_byte) begin
      emit = 1'b1;
      word = {16'd0, half};
      pending_half_nxt = '0;
      upper_next_nxt   = 1'b0;
    end else begin
      pending_half_nxt = half;
      upper_next_nxt   = 1'b1;
    end

    if (!take) begin
      emit             = 1'b0;
      pending_half_nxt = pending_half_r;
      upper_next_nxt   = upper_next_r;
    end

    out_valid_nxt = emit || (out_valid_r && !out_tready);
    out_data_nxt  = emit ? word : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_half_r <= '0;
      upper_next_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      pending_half_r <= pending_half_nxt;
      upper_next_r   <= upper_next_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ITWP_ASSERT_NXT(a_read_emits, clk, rst_n,
    take && (stg.item.opcode == itwp_pkg::OP_READ),
    out_valid_r && (out_data_r[26:24] == itwp_pkg::TAG_RECV) && !upper_next_r,
    "read request did not produce a receive word")
  `ITWP_ASSERT_NXT(a_last_clears, clk, rst_n,
    take && stg.item.last_byte,
    !upper_next_r && (pending_half_r == 16'd0),
    "pairing state not cleared after the last byte")
  `ITWP_ASSERT_NXT(a_no_emit_no_word, clk, rst_n,
    take && !emit,
    !out_valid_r && upper_next_r,
    "held half did not wait for its partner")
  `ITWP_ASSERT_NOW(a_pending_tag_bits, clk, rst_n,
    1'b1,
    (pending_half_r[15:11] == 5'd0) && (upper_next_r || (pending_half_r == 16'd0)),
    "pending half holds stray bits")

endmodule

FILE: rtl/i2c_tag_word_packer.sv
// Top level of the I2C tag word packer: input register and pack stage.
// Depends on itwp_pkg, itwp_in_stage and itwp_pack_stage.
//
//   Channel  Direction  Beat contents
//   in_      slave      tdata: slave_address, data_byte, read_length;
//                       tuser: opcode, first_byte; tlast: last_byte
//   out_     master     tdata: fifo_word
//
// One beat is accepted per cycle while out_tready does not stall the pipeline. Its result
// is registered in the input stage and then in the pack stage before it is on out_tdata.
// A write byte that only fills the lower half produces no output beat.
// Reset clears the held half, the pairing flag and both valid flags.
// A stall on out_tready backs up through the pack stage to in_tready.
module i2c_tag_word_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // slave_address[6:0], data_byte[14:7],
                                   // read_length[30:15], zero[31]
  input  logic [1:0]  in_tuser,    // opcode[0], first_byte[1]
  input  logic        in_tlast,    // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // fifo_word[31:0]
);

  itwp_pkg::stage_t stg;
  logic             stg_ready;

  itwp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .stg       (stg),
    .stg_ready (stg_ready)
  );

  itwp_pack_stage u_pack_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .stg        (stg),
    .stg_ready  (stg_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: test/i2c_tag_word_packer_test.sv
// Self-checking testbench for the I2C tag word packer: directed rows, then random traffic.
// Each accepted input beat is run through a local packing model, and every output word is
// checked against it or the word of its row. Depends on itwp_pkg and i2c_tag_word_packer.
module i2c_tag_word_packer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 8;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  // One row of the directed table. A row with word_given set carries its output word.
  typedef struct {
    itwp_pkg::opcode_t op;
    logic [6:0]        addr;
    logic [7:0]        dbyte;
    logic              first;
    logic              last;
    logic [15:0]       rlen;
    bit                word_given;
    logic [31:0]       word;
  } stim_row_t;

  stim_row_t   directed_rows[$];
  logic [31:0] fifo_words_due[$];
  logic [15:0] held_half;
  bit          pair_upper;
  int          fail_count;
  int          cycle_count;
  bit          no_gaps;

  i2c_tag_word_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Packing model: updates the held half and returns 1 when a word leaves the block.
  function automatic bit pack_item(input itwp_pkg::opcode_t op, input logic [6:0] addr,
                                   input logic [7:0] dbyte, input logic first,
                                   input logic last, input logic [15:0] rlen,
                                   output logic [31:0] word);
    logic [15:0] half;
    logic [7:0]  len;
    word = '0;
    if (op == itwp_pkg::OP_READ) begin
      len = (rlen >= 16'd256) ? 8'd0 : rlen[7:0];
      word = {5'b0, itwp_pkg::TAG_RECV, len, 5'b0, itwp_pkg::TAG_START, addr, 1'b1};
      held_half = '0;
      pair_upper = 1'b0;
      return 1'b1;
    end
    if (first) begin
      held_half = {5'b0, itwp_pkg::TAG_START, addr, 1'b0};
      pair_upper = 1'b1;
    end
    half = {5'b0, (last ? itwp_pkg::TAG_STOP : itwp_pkg::TAG_DATA), dbyte};
    if (pair_upper || last) begin
      word = pair_upper ? {half, held_half} : {16'b0, half};
      held_half = '0;
      pair_upper = 1'b0;
      return 1'b1;
    end
    held_half = half;
    pair_upper = 1'b1;
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Entered and left at a falling edge; holds the beat until the block takes it.
  task automatic send_item(input itwp_pkg::opcode_t op, input logic [6:0] addr,
                           input logic [7:0] dbyte, input logic first,
                           input logic last, input logic [15:0] rlen,
                           input bit word_given, input logic [31:0] given_word);
    int          gap;
    logic [31:0] word;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, rlen, dbyte, addr};
    in_tuser  <= {first, op};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (pack_item(op, addr, dbyte, first, last, rlen, word) || word_given)
      fifo_words_due.push_back(word_given ? given_word : word);
    @(negedge clk);
  endtask

  task automatic drain_words();
    in_tvalid <= 1'b0;
    while (fifo_words_due.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input itwp_pkg::opcode_t op, input logic [6:0] addr,
                         input logic [7:0] dbyte,
                         input logic first, input logic last, input logic [15:0] rlen,
                         input bit word_given, input logic [31:0] word);
    stim_row_t row;
    row.op = op;
    row.addr = addr;
    row.dbyte = dbyte;
    row.first = first;
    row.last = last;
    row.rlen = rlen;
    row.word_given = word_given;
    row.word = word;
    directed_rows.push_back(row);
  endtask

  // Output side: random stalls, with long stretches of steady readiness mixed in.
  initial begin
    int hold;
    int r;
    bit rdy;
    out_tready = 1'b0;
    hold = 0;
    rdy = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          rdy = 1'b1;
          hold = $urandom_range(1, 40);
        end else if (r < 88) begin
          rdy = 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          rdy = 1'b0;
          hold = $urandom_range(10, 30);
        end
      end
      out_tready <= rdy;
      hold--;
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (fifo_words_due.size() == 0) begin
        $display("%0t: word with none due: expected nothing, actual fifo_word %h",
                 $time, out_tdata);
        fail_count++;
      end else begin
        want = fifo_words_due.pop_front();
        if (out_tdata !== want) begin
          $display("%0t: fifo_word mismatch: expected %h, actual %h", $time, want, out_tdata);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          n;
    int          r;
    logic [6:0]  addr;
    logic [15:0] rlen;
    bit          drop_first;
    bit          drop_last;
    bit          paused;
    fail_count = 0;
    cycle_count = 0;
    held_half = '0;
    pair_upper = 1'b0;
    no_gaps = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;

    // Reads with every length class; the byte fields of a read are ignored.
    add_row(itwp_pkg::OP_READ,  7'h00, 8'hFF, 1'b1, 1'b1, 16'd1,     1, 32'h0401_0101);
    add_row(itwp_pkg::OP_READ,  7'h7F, 8'h00, 1'b0, 1'b0, 16'd255,   1, 32'h04FF_01FF);
    add_row(itwp_pkg::OP_READ,  7'h55, 8'hFF, 1'b1, 1'b0, 16'd256,   1, 32'h0400_01AB);
    add_row(itwp_pkg::OP_READ,  7'h2A, 8'h00, 1'b0, 1'b1, 16'd65535, 1, 32'h0400_0155);
    add_row(itwp_pkg::OP_READ,  7'h01, 8'hFF, 1'b1, 1'b1, 16'd0,     1, 32'h0400_0103);
    // One-byte message, then a three-byte message with pairing across beats.
    add_row(itwp_pkg::OP_WRITE, 7'h7F, 8'hFF, 1'b1, 1'b1, 16'hFFFF,  1, 32'h03FF_01FE);
    add_row(itwp_pkg::OP_WRITE, 7'h00, 8'h00, 1'b1, 1'b0, 16'hFFFF,  1, 32'h0200_0100);
    add_row(itwp_pkg::OP_WRITE, 7'h33, 8'hFF, 1'b0, 1'b0, 16'h0000,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h33, 8'h80, 1'b0, 1'b1, 16'h8000,  0, '0);
    // Bytes outside any message start a fresh lower half without a start half.
    add_row(itwp_pkg::OP_WRITE, 7'h11, 8'h12, 1'b0, 1'b1, 16'h0001,  1, 32'h0000_0312);
    add_row(itwp_pkg::OP_WRITE, 7'h11, 8'h34, 1'b0, 1'b0, 16'h0001,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h11, 8'h56, 1'b0, 1'b0, 16'h0001,  0, '0);
    // A read drops a half that is still waiting for its partner.
    add_row(itwp_pkg::OP_WRITE, 7'h11, 8'h77, 1'b0, 1'b0, 16'h0001,  0, '0);
    add_row(itwp_pkg::OP_READ,  7'h03, 8'h77, 1'b0, 1'b0, 16'd2,     1, 32'h0402_0107);
    // A new message opening while a data half is held replaces that half.
    add_row(itwp_pkg::OP_WRITE, 7'h09, 8'hAA, 1'b1, 1'b0, 16'h1234,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h09, 8'hBB, 1'b0, 1'b0, 16'h1234,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h0A, 8'hCC, 1'b1, 1'b1, 16'h1234,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h0A, 8'hDD, 1'b0, 1'b0, 16'h5678,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h7F, 8'h00, 1'b1, 1'b0, 16'h5678,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h7F, 8'h01, 1'b0, 1'b0, 16'h5678,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h7F, 8'h02, 1'b0, 1'b0, 16'h5678,  0, '0);
    add_row(itwp_pkg::OP_WRITE, 7'h7F, 8'hFE, 1'b0, 1'b1, 16'h5678,  0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].dbyte,
                directed_rows[i].first, directed_rows[i].last, directed_rows[i].rlen,
                directed_rows[i].word_given, directed_rows[i].word);
    drain_words();

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain_words();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 62) begin
        // Mostly well-formed messages; a few lose their opening or closing flag.
        addr = 7'($urandom_range(0, 127));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        drop_first = ($urandom_range(0, 9) == 0);
        drop_last = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n; k++)
          send_item(itwp_pkg::OP_WRITE, addr, 8'($urandom_range(0, 255)),
                    (k == 0) && !drop_first, (k == n - 1) && !drop_last,
                    16'($urandom), 0, '0);
        sent += n;
      end else if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 55)
          rlen = 16'($urandom_range(1, 255));
        else if (r < 85)
          rlen = 16'($urandom_range(256, 65535));
        else begin
          case ($urandom_range(0, 3))
            0: rlen = 16'd1;
            1: rlen = 16'd255;
            2: rlen = 16'd256;
            default: rlen = 16'd65535;
          endcase
        end
        send_item(itwp_pkg::OP_READ, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rlen, 0, '0);
        sent++;
      end else begin
        send_item($urandom_range(0, 1) ? itwp_pkg::OP_READ : itwp_pkg::OP_WRITE,
                  7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 16'($urandom), 0, '0);
        sent++;
      end
    end

    drain_words();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && fifo_words_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
